// ===== sv/spime_pkg.sv =====
`timescale 1ns / 1ps

package spime_pkg;

    // register map, byte offsets
    localparam logic [11:0] REG_CTL    = 12'h000;
    localparam logic [11:0] REG_STATUS = 12'h004;
    localparam logic [11:0] REG_DATA   = 12'h008;
    localparam logic [11:0] REG_CS     = 12'h00C;

    // access kind
    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    // control bits kept on a control write
    localparam logic [2:0] CTL_BOTH = 3'b101;

    // status bit positions
    localparam int ST_RX_FULL  = 0;
    localparam int ST_TX_EMPTY = 1;
    localparam int ST_OVERRUN  = 4;

    // eeprom command bytes
    localparam logic [7:0] CMD_READ   = 8'h03;
    localparam logic [7:0] CMD_STATUS = 8'h05;
    localparam logic [7:0] CMD_WREN   = 8'h06;
    localparam logic [7:0] CMD_WRITE  = 8'h02;

    // value of a store byte never written since reset
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    typedef logic [7:0] t_byte;

    function automatic logic is_command(input t_byte b);
        is_command = (b == CMD_READ) || (b == CMD_STATUS) ||
                     (b == CMD_WREN) || (b == CMD_WRITE);
    endfunction

endpackage

// ===== sv/spi_master_with_eeprom.sv =====
`timescale 1ns / 1ps
// channel  | dir | tdata                                   | tuser
// ---------+-----+-----------------------------------------+-----------------
// s_axis   | in  | [11:0] reg_offset, [43:12] write_data   | [0] opcode
// m_axis   | out | [7:0] read_data                         | -
//
// every request gives one result; the result passes through the input register,
// then the result register, before it leaves; one request is taken every cycle
// when the result side keeps up
// reset (i_rst_n low at a clock edge) empties both registers and marks every
// store byte as erased through a per-byte valid flag; no sweep is needed
// a stalled result holds the input register, which then stalls s_axis
module spi_master_with_eeprom #(
    parameter int STORE_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [11:0] reg_offset, [43:12] write_data, rest zero
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] read_data
);
    import spime_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    // command machine phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_STATUS  = 3'd1;
    localparam logic [2:0] PH_RD_ADDR = 3'd2;
    localparam logic [2:0] PH_RD_DATA = 3'd3;
    localparam logic [2:0] PH_WR_ADDR = 3'd4;
    localparam logic [2:0] PH_WR_DATA = 3'd5;

    // input register
    logic        r_in_v;
    logic        r_in_op;
    logic [11:0] r_in_off;
    logic [31:0] r_in_wdata;

    // result register
    logic        r_out_v;
    t_byte       r_out_data;

    // block state
    logic [2:0]  r_ctl, n_ctl;
    logic [4:0]  r_status, n_status;
    t_byte       r_data_byte, n_data_byte;
    logic        r_db_mem, n_db_mem;      // data byte comes from the store read register
    logic        r_cs, n_cs;
    logic        r_wel, n_wel;
    t_byte       r_ptr, n_ptr;
    logic        r_seen, n_seen;
    logic [2:0]  r_phase, n_phase;

    // store, its per-byte written flags and the registered read
    t_byte                  r_mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] r_valid;
    t_byte                  r_mq;
    logic                   r_mq_v;

    logic        advance;
    logic        mem_we;
    logic        mem_re;
    logic        do_idle;
    t_byte       answer;
    t_byte       n_result;
    t_byte       db_eff;
    t_byte       wbyte;
    logic [AW-1:0] idx;

    assign advance       = r_in_v && (!r_out_v || m_axis_tready);
    assign s_axis_tready = !r_in_v || advance;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;

    assign db_eff = r_db_mem ? (r_mq_v ? r_mq : ERASED_BYTE) : r_data_byte;
    assign wbyte  = r_in_wdata[7:0];
    assign idx    = r_ptr[AW-1:0];

    always_comb begin
        n_ctl       = r_ctl;
        n_status    = r_status;
        n_data_byte = r_data_byte;
        n_db_mem    = r_db_mem;
        n_cs        = r_cs;
        n_wel       = r_wel;
        n_ptr       = r_ptr;
        n_seen      = r_seen;
        n_phase     = r_phase;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        do_idle     = 1'b0;
        answer      = '0;
        n_result    = '0;

        if (r_in_op == ACC_WRITE) begin
            if (r_in_off == REG_CTL) begin
                n_ctl = r_in_wdata[2:0] & CTL_BOTH;
                if ((r_in_wdata[2:0] & CTL_BOTH) == CTL_BOTH) begin
                    n_status[ST_TX_EMPTY] = 1'b1;
                end else begin
                    n_status = '0;
                end
            end else if (r_in_off == REG_DATA) begin
                if (r_ctl == CTL_BOTH) begin
                    if (r_status[ST_RX_FULL]) begin
                        n_status[ST_OVERRUN] = 1'b1;
                    end
                    case (r_phase)
                        PH_IDLE: begin
                            do_idle = 1'b1;
                        end
                        PH_STATUS: begin
                            n_phase = PH_IDLE;
                            answer  = {6'd0, r_wel, 1'b0};
                        end
                        PH_RD_ADDR: begin
                            n_ptr   = wbyte;
                            n_phase = PH_RD_DATA;
                        end
                        PH_RD_DATA: begin
                            if (is_command(wbyte)) begin
                                n_phase = PH_IDLE;
                                do_idle = 1'b1;
                            end else begin
                                mem_re = 1'b1;
                                n_ptr  = r_ptr + 8'd1;
                            end
                        end
                        PH_WR_ADDR: begin
                            n_ptr   = wbyte;
                            n_seen  = 1'b0;
                            n_phase = PH_WR_DATA;
                        end
                        PH_WR_DATA: begin
                            if (r_seen && is_command(wbyte)) begin
                                n_wel   = 1'b0;
                                n_phase = PH_IDLE;
                                do_idle = 1'b1;
                            end else begin
                                mem_we = 1'b1;
                                n_ptr  = r_ptr + 8'd1;
                                n_seen = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    // a fresh command byte, also when it ends a burst
                    if (do_idle) begin
                        if (wbyte == CMD_WREN) begin
                            n_wel = 1'b1;
                        end else if (wbyte == CMD_STATUS) begin
                            n_phase = PH_STATUS;
                        end else if (wbyte == CMD_READ) begin
                            n_phase = PH_RD_ADDR;
                        end else if (wbyte == CMD_WRITE) begin
                            if (n_wel) begin
                                n_phase = PH_WR_ADDR;
                            end
                        end
                    end
                    n_data_byte = answer;
                    n_db_mem    = mem_re;
                    n_status[ST_RX_FULL]  = 1'b1;
                    n_status[ST_TX_EMPTY] = 1'b1;
                end
            end else if (r_in_off == REG_CS) begin
                n_cs = r_in_wdata[0];
            end
        end else begin
            if (r_in_off == REG_CTL) begin
                n_result = {5'd0, r_ctl};
            end else if (r_in_off == REG_STATUS) begin
                n_result = {3'd0, r_status};
            end else if (r_in_off == REG_DATA) begin
                n_result = db_eff;
                n_status[ST_RX_FULL] = 1'b0;
            end else if (r_in_off == REG_CS) begin
                n_result = {7'd0, r_cs};
            end
        end
    end

    // handshake registers and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v      <= 1'b0;
            r_out_v     <= 1'b0;
            r_ctl       <= '0;
            r_status    <= '0;
            r_data_byte <= '0;
            r_db_mem    <= 1'b0;
            r_cs        <= 1'b0;
            r_wel       <= 1'b0;
            r_ptr       <= '0;
            r_seen      <= 1'b0;
            r_phase     <= PH_IDLE;
            r_valid     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_v <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (advance) begin
                r_ctl       <= n_ctl;
                r_status    <= n_status;
                r_data_byte <= n_data_byte;
                r_db_mem    <= n_db_mem;
                r_cs        <= n_cs;
                r_wel       <= n_wel;
                r_ptr       <= n_ptr;
                r_seen      <= n_seen;
                r_phase     <= n_phase;
                if (mem_we) begin
                    r_valid[idx] <= 1'b1;
                end
            end
        end
    end

    // payload: input capture, result, store write and registered store read
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op    <= s_axis_tuser[0];
            r_in_off   <= s_axis_tdata[11:0];
            r_in_wdata <= s_axis_tdata[43:12];
        end
        if (advance) begin
            r_out_data <= n_result;
        end
        if (advance && mem_we) begin
            r_mem[idx] <= wbyte;
        end
        if (advance && mem_re) begin
            r_mq   <= r_mem[idx];
            r_mq_v <= r_valid[idx];
        end
    end

endmodule

// ===== sv/spime_chk.sv =====
`timescale 1ns / 1ps

module spime_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // result side empty right after reset
    a_out_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // input side open right after reset
    a_in_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("request side not ready after reset");

    // a new result must follow a taken request, through the input and result registers
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching request");

    // stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind spi_master_with_eeprom spime_chk u_spime_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
